### rtl/dlh_pkg.sv
// Package for the dual latency histogram: sizes, beat types, FSM states
// and the controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package dlh_pkg;

   localparam int BIN_COUNT = 4096;
   localparam int BIN_IDX_W = $clog2(BIN_COUNT);
   localparam int LAT_W     = 16;
   localparam int CNT_W     = 16;
   localparam int IDX_W     = 12;
   localparam int EXT_W     = 17;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_READ   = 1'b1;
   localparam logic CH_ISR    = 1'b0;
   localparam logic CH_TASK   = 1'b1;

   typedef struct packed {
      logic             op;
      logic             channel;
      logic [LAT_W-1:0] latency;
      logic [IDX_W-1:0] bin_index;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] isr_count;
      logic [CNT_W-1:0] task_count;
      logic [LAT_W-1:0] isr_max;
      logic [LAT_W-1:0] task_max;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                 capture;
      logic                 mem_rd;
      logic                 commit;
      logic                 clr_we;
      logic [BIN_IDX_W-1:0] clr_addr;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

### rtl/dlh_ctrl.sv
// Controller FSM: clearing pass after reset, then accept / lookup / finish.
// Depends on dlh_pkg.
`timescale 1ns / 1ps

module dlh_ctrl
   import dlh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type            state_ff, state_in;
   logic [BIN_IDX_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic                 clr_last;

   assign clr_last = (clr_cnt_ff == BIN_IDX_W'(BIN_COUNT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + BIN_IDX_W'(1);
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.clr_addr = clr_cnt_ff;
      req_stall    = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_we = 1'b1;
         end
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_LOOKUP: begin
            cmd.mem_rd = 1'b1;
         end
         ST_FINISH: begin
            cmd.commit = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### rtl/dlh_datapath.sv
// Datapath: request register, two bin memories, peak registers and the
// result register. Depends on dlh_pkg.
`timescale 1ns / 1ps

module dlh_datapath
   import dlh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [EXT_W-1:0] BIN_LIMIT = EXT_W'(BIN_COUNT);
   localparam logic [EXT_W-1:0] BIN_LAST  = EXT_W'(BIN_COUNT - 1);

   logic [CNT_W-1:0] isr_mem  [BIN_COUNT];
   logic [CNT_W-1:0] task_mem [BIN_COUNT];

   req_type              req_ff;
   logic [CNT_W-1:0]     isr_rd_ff, task_rd_ff;
   logic [LAT_W-1:0]     isr_peak_ff, isr_peak_in;
   logic [LAT_W-1:0]     task_peak_ff, task_peak_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [EXT_W-1:0]     lat_ext, idx_ext, rec_bin, sel_ext;
   logic [BIN_IDX_W-1:0] addr;
   logic                 is_record, rd_in_range;
   logic [CNT_W-1:0]     isr_inc, task_inc;

   assign lat_ext     = EXT_W'(req_ff.latency);
   assign idx_ext     = EXT_W'(req_ff.bin_index);
   assign rec_bin     = (lat_ext >= BIN_LIMIT) ? BIN_LAST : lat_ext;
   assign is_record   = (req_ff.op == OP_RECORD);
   assign sel_ext     = is_record ? rec_bin : idx_ext;
   assign addr        = sel_ext[BIN_IDX_W-1:0];
   assign rd_in_range = (idx_ext < BIN_LIMIT);
   assign isr_inc     = isr_rd_ff + CNT_W'(1);
   assign task_inc    = task_rd_ff + CNT_W'(1);

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_we) begin
         isr_mem[cmd.clr_addr]  <= '0;
         task_mem[cmd.clr_addr] <= '0;
      end else if (cmd.commit && is_record) begin
         if (req_ff.channel == CH_ISR) begin
            isr_mem[addr] <= isr_inc;
         end else begin
            task_mem[addr] <= task_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         isr_rd_ff  <= isr_mem[addr];
         task_rd_ff <= task_mem[addr];
      end
   end

   always_comb begin
      isr_peak_in  = isr_peak_ff;
      task_peak_in = task_peak_ff;
      if (cmd.commit && is_record) begin
         if (req_ff.channel == CH_ISR) begin
            if (req_ff.latency > isr_peak_ff) begin
               isr_peak_in = req_ff.latency;
            end
         end else begin
            if (req_ff.latency > task_peak_ff) begin
               task_peak_in = req_ff.latency;
            end
         end
      end
   end

   always_comb begin
      rsp_data_in          = rsp_data_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      if (cmd.commit) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.isr_max    = isr_peak_in;
         rsp_data_in.task_max   = task_peak_in;
         if (!is_record && rd_in_range) begin
            rsp_data_in.isr_count  = isr_rd_ff;
            rsp_data_in.task_count = task_rd_ff;
         end else begin
            rsp_data_in.isr_count  = '0;
            rsp_data_in.task_count = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         isr_peak_ff  <= '0;
         task_peak_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         isr_peak_ff  <= isr_peak_in;
         task_peak_ff <= task_peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### rtl/dual_latency_histogram_top.sv
// Top level of the dual latency histogram: controller plus datapath.
// Depends on dlh_pkg, dlh_ctrl and dlh_datapath.
//
//   channel   handshake              payload
//   req_      req_valid / req_stall  req_data (op, channel, latency, bin_index)
//   rsp_      rsp_valid / rsp_stall  rsp_data (isr_count, task_count, isr_max, task_max)
//
// Each request passes through accept, bin memory read, then update and result load.
// Requests are handled one at a time; the result register frees the request side.
// After reset a clearing pass zeroes all BIN_COUNT (4096) entries of both bin
// memories; req_stall stays high during it.
// A result stalled on rsp_ holds the next request in its final cycle.
`timescale 1ns / 1ps

module dual_latency_histogram_top
   import dlh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   dlh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dlh_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/dlh_checker.sv
// Port-level checks for the dual latency histogram, bound to the top level.
// Depends on dlh_pkg and dual_latency_histogram_top.
`timescale 1ns / 1ps

module dlh_checker
   import dlh_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request side open right after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous beat in flight");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a beat in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result beat changed");

endmodule

bind dual_latency_histogram_top dlh_checker u_dlh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
